@@ sv/fla_pkg.sv @@
// fla_pkg: shared constants, command and status codes of the free-list page allocator.
// No dependencies; imported by fla_addr_chk, fla_seq, fla_checker and free_list_page_allocator.
`default_nettype none

package fla_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned COUNT_MAX = 65535;

  localparam int unsigned REGION_BYTES_DEF = 1024 * 1024;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REINIT = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_FAIL    = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ sv/free_list_page_allocator.sv @@
// free_list_page_allocator: top level; region base register and the allocator parts.
// Depends on fla_pkg, fla_link_ram, fla_addr_chk and fla_seq.
`default_nettype none

// LIFO page allocator over REGION_BYTES / PAGE_BYTES pages (PAGE_BYTES a power of two).
// Free pages form a linked stack held in a registered-read link table; the head index
// and free count live in registers. Allocate and free pass an accept step that reads
// the link entry at the head, then an execute step that uses it and waits while the
// output register is held. Re-initialize writes one table entry for each page whose
// address neither wraps nor is null. Validate does one table read per list entry; it
// stops early once the walk reaches the count. After reset the link table is filled,
// one entry per page, with in_stall_o high; region_base may be written during that
// time. A finished result waits in the output register while the next item is accepted.
module free_list_page_allocator
  import fla_pkg::*;
#(
  parameter int unsigned REGION_BYTES = REGION_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ADDR_W-1:0]   cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          command_i,
  input  wire logic [ADDR_W-1:0]   page_address_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic [ADDR_W-1:0]        allocated_address_o,
  output logic [COUNT_W-1:0]       free_count_o
);

  localparam int unsigned NUM_PAGES = REGION_BYTES / PAGE_BYTES;
  localparam int unsigned IDX_W     = $clog2(NUM_PAGES + 1);
  localparam int unsigned LINK_AW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  logic [ADDR_W-1:0]  region_base_q;
  logic [ADDR_W-1:0]  chk_addr;
  logic               chk_ok;
  logic [IDX_W-1:0]   chk_idx;
  logic               ram_we;
  logic [LINK_AW-1:0] ram_waddr;
  logic [IDX_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [LINK_AW-1:0] ram_raddr;
  logic [IDX_W-1:0]   ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
    end else if (cfg_we_i) begin
      region_base_q <= cfg_data_i;
    end
  end

  fla_link_ram #(
    .DEPTH  (NUM_PAGES),
    .DATA_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fla_addr_chk #(
    .REGION_BYTES (REGION_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_chk (
    .region_base_i  (region_base_q),
    .page_address_i (chk_addr),
    .ok_o           (chk_ok),
    .idx_o          (chk_idx)
  );

  fla_seq #(
    .REGION_BYTES (REGION_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .region_base_i       (region_base_q),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .page_address_i      (page_address_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .allocated_address_o (allocated_address_o),
    .free_count_o        (free_count_o),
    .chk_addr_o          (chk_addr),
    .chk_ok_i            (chk_ok),
    .chk_idx_i           (chk_idx),
    .ram_we_o            (ram_we),
    .ram_waddr_o         (ram_waddr),
    .ram_wdata_o         (ram_wdata),
    .ram_re_o            (ram_re),
    .ram_raddr_o         (ram_raddr),
    .ram_rdata_i         (ram_rdata)
  );

endmodule

`default_nettype wire

@@ sv/fla_link_ram.sv @@
// fla_link_ram: single-port-write, single-port-read link table, read data registered.
// Depends on nothing; used by free_list_page_allocator.
`default_nettype none

module fla_link_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 9,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/fla_addr_chk.sv @@
// fla_addr_chk: null, range and alignment check of a freed page address, page index out.
// Depends on fla_pkg; used by free_list_page_allocator.
`default_nettype none

module fla_addr_chk
  import fla_pkg::*;
#(
  parameter int unsigned REGION_BYTES = REGION_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
  localparam int unsigned NUM_PAGES   = REGION_BYTES / PAGE_BYTES,
  localparam int unsigned IDX_W       = $clog2(NUM_PAGES + 1)
) (
  input  wire logic [ADDR_W-1:0] region_base_i,
  input  wire logic [ADDR_W-1:0] page_address_i,
  output logic                   ok_o,
  output logic      [IDX_W-1:0]  idx_o
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] HI_OFF = ADDR_W'(REGION_BYTES - PAGE_BYTES);
  localparam logic [ADDR_W-1:0] NUM_W  = ADDR_W'(NUM_PAGES);
  localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'(PAGE_BYTES - 1);

  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] idx_full;
  logic              below;

  always_comb begin
    below    = page_address_i < region_base_i;
    offset   = page_address_i - region_base_i;
    idx_full = offset >> PAGE_SHIFT;
    ok_o     = (page_address_i != '0) && !below && (offset <= HI_OFF) &&
               ((offset & LOW_MASK) == '0) && (idx_full < NUM_W);
    idx_o    = idx_full[IDX_W-1:0];
  end

endmodule

`default_nettype wire

@@ sv/fla_seq.sv @@
// fla_seq: command sequencer; head and count registers, link-table walks, result register.
// Depends on fla_pkg; drives fla_link_ram and takes the result of fla_addr_chk.
`default_nettype none

module fla_seq
  import fla_pkg::*;
#(
  parameter int unsigned REGION_BYTES = REGION_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
  localparam int unsigned NUM_PAGES   = REGION_BYTES / PAGE_BYTES,
  localparam int unsigned IDX_W       = $clog2(NUM_PAGES + 1),
  localparam int unsigned LINK_AW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ADDR_W-1:0]   region_base_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          command_i,
  input  wire logic [ADDR_W-1:0]   page_address_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic [ADDR_W-1:0]        allocated_address_o,
  output logic [COUNT_W-1:0]       free_count_o,
  output logic [ADDR_W-1:0]        chk_addr_o,
  input  wire logic                chk_ok_i,
  input  wire logic [IDX_W-1:0]    chk_idx_i,
  output logic                     ram_we_o,
  output logic [LINK_AW-1:0]       ram_waddr_o,
  output logic [IDX_W-1:0]         ram_wdata_o,
  output logic                     ram_re_o,
  output logic [LINK_AW-1:0]       ram_raddr_o,
  input  wire logic [IDX_W-1:0]    ram_rdata_i
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);
  localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(COUNT_MAX);
  localparam logic [COUNT_W-1:0] CNT_RESET =
    COUNT_W'((NUM_PAGES > COUNT_MAX) ? COUNT_MAX : NUM_PAGES);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]   sweep_q, sweep_d;
  logic [COUNT_W-1:0] walked_q, walked_d;
  logic               from_ram_q, from_ram_d;
  cmd_e               cmd_q;
  logic [ADDR_W-1:0]  addr_q;

  logic               out_valid_q;
  status_e            status_q;
  logic [ADDR_W-1:0]  alloc_q;
  logic [COUNT_W-1:0] free_count_q;

  logic               out_free;
  logic               accept;
  logic               deliver;
  status_e            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [IDX_W-1:0]   cur;
  logic [ADDR_W:0]    sweep_sum;
  logic               sweep_keep;
  logic [COUNT_W-1:0] count_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign chk_addr_o = addr_q;
  assign count_inc  = (count_q < CNT_MAX) ? count_q + 1'b1 : count_q;
  assign cur        = from_ram_q ? ram_rdata_i : head_q;

  // a re-init page is kept when its address neither wraps nor is null
  assign sweep_sum  = {1'b0, region_base_i} + {1'b0, ADDR_W'(sweep_q) << PAGE_SHIFT};
  assign sweep_keep = !sweep_sum[ADDR_W] && (sweep_sum[ADDR_W-1:0] != '0);

  // reads happen only in idle and walk, writes only elsewhere: no same-cycle overlap
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    sweep_d     = sweep_q;
    walked_d    = walked_q;
    from_ram_d  = from_ram_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = sweep_q[LINK_AW-1:0];
    ram_wdata_o = head_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q[LINK_AW-1:0];
    deliver     = 1'b0;
    res_status  = STAT_OK;
    res_addr    = '0;

    unique case (state_q)
      S_INIT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (sweep_q == '0) ? NULL_IDX : sweep_q - 1'b1;
        sweep_d     = sweep_q + 1'b1;
        if (sweep_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_re_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (cmd_q)
            CMD_ALLOC: begin
              deliver = 1'b1;
              state_d = S_IDLE;
              if (head_q != NULL_IDX) begin
                res_addr = region_base_i + (ADDR_W'(head_q) << PAGE_SHIFT);
                head_d   = ram_rdata_i;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end else begin
                res_status = STAT_EMPTY;
              end
            end
            CMD_FREE: begin
              deliver = 1'b1;
              state_d = S_IDLE;
              if (chk_ok_i) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = chk_idx_i[LINK_AW-1:0];
                head_d      = chk_idx_i;
                count_d     = count_inc;
              end else begin
                res_status = STAT_IGNORED;
              end
            end
            CMD_REINIT: begin
              head_d  = NULL_IDX;
              count_d = '0;
              sweep_d = '0;
              state_d = S_SWEEP;
            end
            CMD_CHECK: begin
              if (ADDR_W'(count_q) > ADDR_W'(NUM_PAGES)) begin
                deliver    = 1'b1;
                res_status = STAT_FAIL;
                state_d    = S_IDLE;
              end else begin
                walked_d   = '0;
                from_ram_d = 1'b0;
                state_d    = S_WALK;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        // a path that reaches null has no repeat; a cycle runs past the count
        if (cur == NULL_IDX) begin
          if (out_free) begin
            deliver    = 1'b1;
            res_status = (walked_q == count_q) ? STAT_OK : STAT_FAIL;
            state_d    = S_IDLE;
          end
        end else if (walked_q == count_q) begin
          if (out_free) begin
            deliver    = 1'b1;
            res_status = STAT_FAIL;
            state_d    = S_IDLE;
          end
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = cur[LINK_AW-1:0];
          walked_d    = walked_q + 1'b1;
          from_ram_d  = 1'b1;
        end
      end
      S_SWEEP: begin
        if (sweep_q == NULL_IDX) begin
          if (out_free) begin
            deliver = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          sweep_d = sweep_q + 1'b1;
          if (sweep_keep) begin
            ram_we_o = 1'b1;
            head_d   = sweep_q;
            count_d  = count_inc;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      head_q      <= (NUM_PAGES == 0) ? NULL_IDX : LAST_IDX;
      count_q     <= CNT_RESET;
      sweep_q     <= '0;
      walked_q    <= '0;
      from_ram_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      sweep_q    <= sweep_d;
      walked_q   <= walked_d;
      from_ram_q <= from_ram_d;
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      addr_q <= page_address_i;
    end
    if (deliver) begin
      status_q     <= res_status;
      alloc_q      <= res_addr;
      free_count_q <= count_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign allocated_address_o = alloc_q;
  assign free_count_o        = free_count_q;

endmodule

`default_nettype wire

@@ sv/fla_checker.sv @@
// fla_checker: port-level assertions for free_list_page_allocator, bound to the top level.
// Depends on fla_pkg.
`default_nettype none

module fla_checker
  import fla_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [1:0]        status_o,
  input wire logic [ADDR_W-1:0] allocated_address_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted without a busy cycle");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

  a_no_addr_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> allocated_address_o == '0)
    else $error("address reported with a non-ok status");

endmodule

bind free_list_page_allocator fla_checker u_fla_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .status_o            (status_o),
  .allocated_address_o (allocated_address_o)
);

`default_nettype wire
